// ===== hdl/ppmd_pkg.sv =====
package ppmd_pkg;

  // Field widths
  localparam int SLOT_W     = 4;
  localparam int ERR_W      = 8;
  localparam int US_W       = 16;
  localparam int THR_W      = 16;
  localparam int Q_W        = 20;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int TICK_MAX_W = 32;
  localparam int PROD_W     = TICK_MAX_W + Q_W;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TICK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TICK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_US_Q16   = 2'd3;

  // Register reset values
  localparam logic [THR_W-1:0] SYNC_THR_RST = 16'd8000;
  localparam logic [THR_W-1:0] MIN_TICK_RST = 16'd1644;
  localparam logic [THR_W-1:0] MAX_TICK_RST = 16'd3834;
  localparam logic [Q_W-1:0]   US_Q16_RST   = 20'd35890;

  // One classified input, front to back
  typedef struct packed {
    logic                  store;  // write ticks into the frame store
    logic                  done;   // frame complete, drain all slots
    logic [SLOT_W-1:0]     addr;   // store slot
    logic [SLOT_W-1:0]     nslot;  // next slot expected (status result)
    logic [TICK_MAX_W-1:0] ticks;
    logic [ERR_W-1:0]      err;    // error tally after this input
  } ppmd_cmd_t;

endpackage

// ===== hdl/ppmd_front.sv =====
module ppmd_front import ppmd_pkg::*; #(
  parameter int FRAME_SLOTS = 9,
  parameter int TICK_WIDTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TICK_WIDTH-1:0] in_capture_ticks,
  input  logic [THR_W-1:0]      sync_thr,
  input  logic [THR_W-1:0]      min_ticks,
  input  logic [THR_W-1:0]      max_ticks,
  input  logic                  q_full,
  output logic                  q_push,
  output ppmd_cmd_t             q_cmd
);

  localparam int CW = (TICK_WIDTH > THR_W) ? TICK_WIDTH : THR_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic [CW-1:0]     ticks_c;
  logic              in_window;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign ticks_c   = CW'(in_capture_ticks);
  assign in_window = (ticks_c >= CW'(min_ticks)) && (ticks_c <= CW'(max_ticks));

  // Classify the incoming period against the frame state
  always_comb begin
    slot_nxt    = slot_r;
    err_nxt     = err_r;
    q_cmd.store = 1'b0;
    q_cmd.done  = 1'b0;
    q_cmd.addr  = slot_r;
    q_cmd.ticks = TICK_MAX_W'(in_capture_ticks);
    if (slot_r == '0) begin
      if (ticks_c >= CW'(sync_thr)) begin
        q_cmd.store = 1'b1;
        slot_nxt    = SLOT_W'(1);
      end
    end else if (!in_window) begin
      slot_nxt = '0;
      err_nxt  = err_r + ERR_W'(1);
    end else begin
      q_cmd.store = 1'b1;
      if (slot_r == LAST_SLOT) begin
        q_cmd.done = 1'b1;
        slot_nxt   = '0;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
    q_cmd.nslot = slot_nxt;
    q_cmd.err   = err_nxt;
  end

  // Frame position and error tally
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      err_r  <= '0;
    end else if (q_push) begin
      slot_r <= slot_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// ===== hdl/ppmd_fifo.sv =====
module ppmd_fifo import ppmd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ppmd_cmd_t din,
  output logic      full,
  input  logic      pop,
  output ppmd_cmd_t dout,
  output logic      empty
);

  ppmd_cmd_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (QAW+1)'(1);
    if (pop && !push) cnt_nxt = cnt_r - (QAW+1)'(1);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

// ===== hdl/ppmd_back.sv =====
module ppmd_back import ppmd_pkg::*; #(
  parameter int FRAME_SLOTS = 9,
  parameter int TICK_WIDTH  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [Q_W-1:0]    us_q16,
  input  logic              q_empty,
  input  ppmd_cmd_t         q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_frame_valid,
  output logic [SLOT_W-1:0] out_slot,
  output logic [US_W-1:0]   out_pulse_us,
  output logic [ERR_W-1:0]  out_error_count,
  output logic              out_last
);

  localparam int AW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_K = AW'(FRAME_SLOTS - 1);

  // Frame store
  logic [TICK_WIDTH-1:0] mem_r [FRAME_SLOTS];

  // Drain sequencer
  logic             drain_r, drain_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [ERR_W-1:0] drain_err_r, drain_err_nxt;
  logic             adv;

  // Pipeline stages
  logic                  s1_vld_r, s1_vld_nxt, s1_fv_r, s1_fv_nxt, s1_last_r, s1_last_nxt;
  logic [SLOT_W-1:0]     s1_slot_r, s1_slot_nxt;
  logic [ERR_W-1:0]      s1_err_r, s1_err_nxt;
  logic [TICK_WIDTH-1:0] rd_r;
  logic                  s2_vld_r, s2_fv_r, s2_last_r;
  logic [SLOT_W-1:0]     s2_slot_r;
  logic [ERR_W-1:0]      s2_err_r;
  logic [PROD_W-1:0]     prod_r;
  logic [US_W-1:0]       us_sat;

  logic                  out_valid_r, out_fv_r, out_last_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [US_W-1:0]       out_us_r;
  logic [ERR_W-1:0]      out_err_r;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !drain_r && !q_empty;

  // Issue: drain a completed frame slot by slot, else take the next command
  always_comb begin
    drain_nxt     = drain_r;
    k_nxt         = k_r;
    drain_err_nxt = drain_err_r;
    s1_vld_nxt    = 1'b0;
    s1_fv_nxt     = 1'b0;
    s1_last_nxt   = 1'b1;
    s1_slot_nxt   = q_cmd.nslot;
    s1_err_nxt    = q_cmd.err;
    if (drain_r) begin
      s1_vld_nxt  = 1'b1;
      s1_fv_nxt   = 1'b1;
      s1_slot_nxt = SLOT_W'(k_r);
      s1_err_nxt  = drain_err_r;
      s1_last_nxt = (k_r == LAST_K);
      if (k_r == LAST_K) begin
        drain_nxt = 1'b0;
        k_nxt     = '0;
      end else begin
        k_nxt = k_r + AW'(1);
      end
    end else if (q_pop) begin
      if (q_cmd.done) begin
        drain_nxt     = 1'b1;
        k_nxt         = '0;
        drain_err_nxt = q_cmd.err;
      end else begin
        s1_vld_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r     <= 1'b0;
      k_r         <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      drain_r     <= drain_nxt;
      k_r         <= k_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r;
    end
  end

  // Frame store write and registered read
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.store) mem_r[q_cmd.addr[AW-1:0]] <= q_cmd.ticks[TICK_WIDTH-1:0];
    if (adv && drain_r) rd_r <= mem_r[k_r];
  end

  // Saturate the Q16 product to 16 bits
  assign us_sat = (|prod_r[PROD_W-1:US_W+16]) ? {US_W{1'b1}} : prod_r[US_W+15:16];

  // Payload pipeline: metadata, multiply, output register
  always_ff @(posedge clk) begin
    if (adv) begin
      drain_err_r <= drain_err_nxt;
      s1_fv_r     <= s1_fv_nxt;
      s1_last_r   <= s1_last_nxt;
      s1_slot_r   <= s1_slot_nxt;
      s1_err_r    <= s1_err_nxt;
      s2_fv_r     <= s1_fv_r;
      s2_last_r   <= s1_last_r;
      s2_slot_r   <= s1_slot_r;
      s2_err_r    <= s1_err_r;
      prod_r      <= {{(PROD_W-TICK_WIDTH){1'b0}}, rd_r} * {{(PROD_W-Q_W){1'b0}}, us_q16};
      out_fv_r    <= s2_fv_r;
      out_last_r  <= s2_last_r;
      out_slot_r  <= s2_slot_r;
      out_err_r   <= s2_err_r;
      out_us_r    <= s2_fv_r ? us_sat : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_valid = out_fv_r;
  assign out_slot        = out_slot_r;
  assign out_pulse_us    = out_us_r;
  assign out_error_count = out_err_r;
  assign out_last        = out_last_r;

  // Status results are always the only result of their input
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_fv_r |-> out_last_r)
    else $error("status result without last");

  // Frame results end exactly at the final slot
  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fv_r |-> (out_last_r == (out_slot_r == SLOT_W'(FRAME_SLOTS - 1))))
    else $error("frame last flag does not match final slot");

  // Drain counter stays inside the frame
  a_drain_range: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (k_r <= LAST_K))
    else $error("drain index beyond frame");

endmodule

// ===== hdl/ppm_frame_decoder.sv =====
// Path: an accepted transaction is queued; a status result then passes the issue stage, the
//   multiply stage and the output register, and a completed frame is read out slot by slot.
// Throughput: one input transaction per cycle while the queue is not full; the back end takes
//   no queue entry while it drains a completed frame (one result per cycle from the frame store
//   read port, held by out_stall), so a 4-entry queue absorbs inputs meanwhile.
// Reset (synchronous, rst_n low): registers to defaults, waiting for sync, error tally zero.
module ppm_frame_decoder import ppmd_pkg::*; #(
  parameter int FRAME_SLOTS = 9,
  parameter int TICK_WIDTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TICK_WIDTH-1:0] in_capture_ticks,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_frame_valid,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [US_W-1:0]       out_pulse_us,
  output logic [ERR_W-1:0]      out_error_count,
  output logic                  out_last
);

  logic [THR_W-1:0] sync_thr_r, min_ticks_r, max_ticks_r;
  logic [Q_W-1:0]   us_q16_r;

  logic      q_push, q_full, q_pop, q_empty;
  ppmd_cmd_t q_din, q_dout;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_thr_r  <= SYNC_THR_RST;
      min_ticks_r <= MIN_TICK_RST;
      max_ticks_r <= MAX_TICK_RST;
      us_q16_r    <= US_Q16_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_THR: sync_thr_r  <= cfg_wdata[THR_W-1:0];
        REG_MIN_TICK: min_ticks_r <= cfg_wdata[THR_W-1:0];
        REG_MAX_TICK: max_ticks_r <= cfg_wdata[THR_W-1:0];
        REG_US_Q16:   us_q16_r    <= cfg_wdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  ppmd_front #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .TICK_WIDTH  (TICK_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_capture_ticks (in_capture_ticks),
    .sync_thr         (sync_thr_r),
    .min_ticks        (min_ticks_r),
    .max_ticks        (max_ticks_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_din)
  );

  ppmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  ppmd_back #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .TICK_WIDTH  (TICK_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .us_q16          (us_q16_r),
    .q_empty         (q_empty),
    .q_cmd           (q_dout),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_valid (out_frame_valid),
    .out_slot        (out_slot),
    .out_pulse_us    (out_pulse_us),
    .out_error_count (out_error_count),
    .out_last        (out_last)
  );

endmodule

// ===== tb/tb_ppm_frame_decoder.sv =====
module tb_ppm_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import ppmd_pkg::*;

  localparam int FRAME_SLOTS   = 9;
  localparam int TICK_W        = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = FRAME_SLOTS + 8;
  localparam int MAX_PRINTS    = 30;

  // One result transaction as seen on the out_ channel
  typedef struct packed {
    logic              frame_valid;
    logic [SLOT_W-1:0] slot;
    logic [US_W-1:0]   pulse_us;
    logic [ERR_W-1:0]  error_count;
    logic              last;
  } slot_result_t;

  // Frame decoder predictor plus the queue of results it still waits for
  class ppm_frame_checker;
    logic [TICK_W-1:0] sync_thr;
    logic [TICK_W-1:0] win_lo;
    logic [TICK_W-1:0] win_hi;
    logic [Q_W-1:0]    scale_q16;
    int unsigned       next_slot;
    logic [TICK_W-1:0] slot_ticks [FRAME_SLOTS];
    logic [ERR_W-1:0]  drop_tally;
    slot_result_t      due_results [$];
    int mismatches;
    int results_ok;
    int inputs_seen;
    int frames_done;
    int drops;
    int wraps;

    function new();
      sync_thr    = SYNC_THR_RST;
      win_lo      = MIN_TICK_RST;
      win_hi      = MAX_TICK_RST;
      scale_q16   = US_Q16_RST;
      next_slot   = 0;
      drop_tally  = '0;
      mismatches  = 0;
      results_ok  = 0;
      inputs_seen = 0;
      frames_done = 0;
      drops       = 0;
      wraps       = 0;
    endfunction

    // ticks * Q16 factor, truncated, saturated to the output width
    function logic [US_W-1:0] ticks_to_us(logic [TICK_W-1:0] t);
      logic [TICK_W+Q_W-1:0] prod;
      prod = t * scale_q16;
      prod = prod >> 16;
      return (prod > 36'hFFFF) ? '1 : prod[US_W-1:0];
    endfunction

    function void push(logic fv, int unsigned slot, logic [US_W-1:0] us, logic last);
      slot_result_t r;
      r.frame_valid = fv;
      r.slot        = SLOT_W'(slot);
      r.pulse_us    = us;
      r.error_count = drop_tally;
      r.last        = last;
      due_results.push_back(r);
    endfunction

    // Advance the decoder by one accepted period and queue what it yields
    function void decode_ticks(logic [TICK_W-1:0] t);
      inputs_seen++;
      if (next_slot == 0) begin
        if (t >= sync_thr) begin
          slot_ticks[0] = t;
          next_slot = 1;
        end
        push(1'b0, next_slot, '0, 1'b1);
      end else if (t < win_lo || t > win_hi) begin
        // out of window: frame dropped
        next_slot = 0;
        drop_tally++;
        drops++;
        if (drop_tally == '0) wraps++;
        push(1'b0, 0, '0, 1'b1);
      end else begin
        slot_ticks[next_slot] = t;
        if (next_slot == FRAME_SLOTS - 1) begin
          next_slot = 0;
          frames_done++;
          for (int k = 0; k < FRAME_SLOTS; k++)
            push(1'b1, k, ticks_to_us(slot_ticks[k]), k == FRAME_SLOTS - 1);
        end else begin
          next_slot++;
          push(1'b0, next_slot, '0, 1'b1);
        end
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task check_result(slot_result_t got);
      slot_result_t want;
      if (due_results.size() == 0) begin
        report("unexpected result, slot", got.slot, 0);
        return;
      end
      want = due_results.pop_front();
      if (got == want) begin
        results_ok++;
        return;
      end
      if (got.frame_valid !== want.frame_valid)
        report("frame_valid", got.frame_valid, want.frame_valid);
      if (got.slot !== want.slot) report("slot", got.slot, want.slot);
      if (got.pulse_us !== want.pulse_us) report("pulse_us", got.pulse_us, want.pulse_us);
      if (got.error_count !== want.error_count)
        report("error_count", got.error_count, want.error_count);
      if (got.last !== want.last) report("last", got.last, want.last);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n            = 1'b0;
  logic                  cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = REG_SYNC_THR;
  logic [CFG_W-1:0]      cfg_wdata        = '0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic [TICK_W-1:0]     in_capture_ticks = '0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic                  out_frame_valid;
  logic [SLOT_W-1:0]     out_slot;
  logic [US_W-1:0]       out_pulse_us;
  logic [ERR_W-1:0]      out_error_count;
  logic                  out_last;

  ppm_frame_checker frame_checker = new();
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  bit hold_req  = 1'b0;
  int holds_done = 0;
  int cfg_sets   = 0;
  int idle_cycles = 0;

  ppm_frame_decoder #(
    .FRAME_SLOTS(FRAME_SLOTS),
    .TICK_WIDTH (TICK_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_capture_ticks(in_capture_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_valid (out_frame_valid),
    .out_slot        (out_slot),
    .out_pulse_us    (out_pulse_us),
    .out_error_count (out_error_count),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_idle(bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // Channel period inside the current window, edges favored; any value if the window is inverted
  function automatic logic [TICK_W-1:0] valid_tick();
    if (frame_checker.win_lo > frame_checker.win_hi) return TICK_W'($urandom);
    case ($urandom_range(0, 7))
      0: return frame_checker.win_lo;
      1: return frame_checker.win_hi;
      default: return TICK_W'($urandom_range(frame_checker.win_lo, frame_checker.win_hi));
    endcase
  endfunction

  // Period outside the window; falls back to any value when the window is full or inverted
  function automatic logic [TICK_W-1:0] bad_tick();
    if (frame_checker.win_lo > frame_checker.win_hi) return TICK_W'($urandom);
    if (frame_checker.win_lo != '0 && (frame_checker.win_hi == '1 || $urandom_range(0, 1)))
      return TICK_W'($urandom_range(0, int'(frame_checker.win_lo) - 1));
    if (frame_checker.win_hi != '1)
      return TICK_W'($urandom_range(int'(frame_checker.win_hi) + 1, 65535));
    return TICK_W'($urandom);
  endfunction

  function automatic logic [TICK_W-1:0] sync_tick();
    return TICK_W'($urandom_range(frame_checker.sync_thr, 65535));
  endfunction

  // Offer one period and hold it until the block takes the transaction
  task automatic send_ticks(input logic [TICK_W-1:0] t);
    int gap;
    gap = pick_idle(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_capture_ticks <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    frame_checker.decode_ticks(t);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write all four registers; upper bits of 16-bit registers carry junk
  task automatic program_regs(input logic [TICK_W-1:0] thr, input logic [TICK_W-1:0] lo,
                              input logic [TICK_W-1:0] hi, input logic [Q_W-1:0] q);
    cfg_put(REG_SYNC_THR, {4'($urandom), thr});
    cfg_put(REG_MIN_TICK, {4'($urandom), lo});
    cfg_put(REG_MAX_TICK, {4'($urandom), hi});
    cfg_put(REG_US_Q16, q);
    cfg_we <= 1'b0;
    frame_checker.sync_thr  = thr;
    frame_checker.win_lo    = lo;
    frame_checker.win_hi    = hi;
    frame_checker.scale_q16 = q;
    cfg_sets++;
  endtask

  // Drop valid, wait for every pending result, then let the pipe go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (frame_checker.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(input bit broken);
    int keep;
    while (frame_checker.next_slot != 0) send_ticks(bad_tick());
    send_ticks(sync_tick());
    keep = broken ? $urandom_range(0, FRAME_SLOTS - 2) : FRAME_SLOTS - 1;
    repeat (keep) send_ticks(valid_tick());
    if (broken) send_ticks(bad_tick());
  endtask

  task automatic send_noise();
    if (frame_checker.sync_thr != '0 && $urandom_range(0, 1))
      send_ticks(TICK_W'($urandom_range(0, int'(frame_checker.sync_thr) - 1)));
    else
      send_ticks(TICK_W'($urandom));
  endtask

  // Mostly well-formed frames, some broken ones, some noise
  task automatic run_random(input int n, input int hold_at);
    int start;
    int pick;
    start = frame_checker.inputs_seen;
    while (frame_checker.inputs_seen - start < n) begin
      if (hold_at >= 0 && frame_checker.inputs_seen - start >= hold_at) begin
        hold_req = 1'b1;
        hold_at  = -1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) send_frame(1'b0);
      else if (pick < 85) send_frame(1'b1);
      else send_noise();
    end
  endtask

  // Result side: random stalls per transaction, one long hold-off on request
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold     = HOLD_CYCLES;
        hold_req = 1'b0;
        holds_done++;
      end else begin
        hold = pick_idle(recv_calm);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Result check and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0)
        frame_checker.check_result({out_frame_valid, out_slot, out_pulse_us,
                                    out_error_count, out_last});
      if ((out_valid === 1'b1 && out_stall === 1'b0) ||
          (in_valid === 1'b1 && in_stall === 1'b0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset values: short gap, max sync, window edges, drops both sides
    send_ticks(16'd0);
    send_ticks(16'hFFFF);
    send_ticks(16'd1644);
    send_ticks(16'd3834);
    send_ticks(16'd1644);
    send_ticks(16'd3834);
    send_ticks(16'd2000);
    send_ticks(16'd3000);
    send_ticks(16'd2500);
    send_ticks(16'd1700);
    send_ticks(16'd8000);
    send_ticks(16'd1643);
    send_ticks(16'd7999);
    send_ticks(16'd8000);
    send_ticks(16'd3835);
    settle();

    // Directed extremes: every period syncs and fits, largest scale saturates
    program_regs(16'd0, 16'd0, 16'hFFFF, 20'hFFFFF);
    send_ticks(16'hFFFF);
    send_ticks(16'd0);
    send_ticks(16'hFFFF);
    send_ticks(16'h5555);
    send_ticks(16'hAAAA);
    send_ticks(16'd1);
    send_ticks(16'h0042);
    send_ticks(16'h8000);
    send_ticks(16'hFFFE);
    settle();

    // Nominal settings, with one long result hold-off in the middle
    program_regs(16'd8000, 16'd1644, 16'd3834, 20'd35890);
    run_random(100, 50);
    settle();

    // Wide-open window, no idling on either side
    send_calm = 1'b1;
    recv_calm = 1'b1;
    program_regs(16'd0, 16'd0, 16'hFFFF, 20'hFFFFF);
    run_random(60, -1);
    settle();

    // Highest sync threshold, zero scale
    send_calm = 1'b0;
    recv_calm = 1'b0;
    program_regs(16'hFFFF, 16'($urandom_range(0, 4000)), 16'($urandom_range(4000, 65535)),
                 20'd0);
    run_random(50, -1);
    settle();

    // Inverted window: every frame dies at its first channel
    program_regs(16'($urandom_range(1000, 9000)), 16'd3000, 16'd2000, 20'd35890);
    run_random(40, -1);
    settle();

    // Back-to-back burst of dropped frames
    program_regs(16'd0, 16'hFFFF, 16'd0, 20'($urandom));
    send_calm = 1'b1;
    repeat (40) send_ticks(TICK_W'($urandom));
    send_calm = 1'b0;
    settle();

    // Random settings
    repeat (2) begin
      logic [TICK_W-1:0] lo;
      lo = 16'($urandom_range(0, 30000));
      program_regs(16'($urandom_range(4000, 65535)), lo, 16'($urandom_range(lo, 65535)),
                   20'($urandom));
      recv_calm = $urandom_range(0, 1);
      run_random(50, -1);
      settle();
    end

    $display("ran %0d input transactions, %0d results, %0d full frames, %0d dropped frames",
             frame_checker.inputs_seen, frame_checker.results_ok + frame_checker.mismatches,
             frame_checker.frames_done, frame_checker.drops);
    $display("drop tally wrapped %0d time(s), %0d long hold-off(s), %0d register settings",
             frame_checker.wraps, holds_done, cfg_sets);
    if (frame_checker.mismatches == 0 && frame_checker.due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
